### rtl/lognormal_cdf_eval_core_macros.svh
// Assertion helpers for the checker file.
`ifndef LOGNORMAL_CDF_EVAL_CORE_MACROS_SVH
`define LOGNORMAL_CDF_EVAL_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LNCDF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lncdf: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LNCDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lncdf: assertion failed");

`endif

### rtl/lncdf_pkg.sv
package lncdf_pkg;

	localparam int FRAC_BITS = 16;

	localparam logic [29:0] C_LN2       = 30'd744261118;
	localparam logic [29:0] C_INV_SQRT2 = 30'd759250125;
	localparam logic [28:0] C_P         = 29'd351748265;
	localparam logic [30:0] Q30_ONE     = 31'd1073741824;

	localparam logic signed [33:0] C_A5 = 34'sd1139675401;

	// Horner coefficients after the leading one; the last step adds nothing.
	localparam logic signed [33:0] HORNER_COEF [5] = '{
		-34'sd1560310108, 34'sd1526231383, -34'sd305476044, 34'sd273621191, 34'sd0
	};

	localparam int N_TAYLOR = 16;

	// floor((2^32 - 1) / n) for n = 1 .. 16
	localparam logic [31:0] RECIP [N_TAYLOR] = '{
		32'd4294967295, 32'd2147483647, 32'd1431655765, 32'd1073741823,
		32'd858993459,  32'd715827882,  32'd613566756,  32'd536870911,
		32'd477218588,  32'd429496729,  32'd390451572,  32'd357913941,
		32'd330382099,  32'd306783378,  32'd286331153,  32'd268435455
	};

	typedef enum logic [1:0] {
		REG_LOG_MEAN    = 2'd0,
		REG_LOG_STD_DEV = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic               vld;
		logic               last;
		logic               bad;
		logic               neg;
		logic               sat;
		logic               zero;
		logic [4:0]         msb;
		logic [30:0]        mant;
		logic [15:0]        frac;
		logic signed [21:0] lnv;
		logic [22:0]        rem;
		logic [20:0]        nbits;
		logic [20:0]        quo;
		logic [22:0]        dvs;
		logic [19:0]        sv;
		logic [23:0]        u;
		logic signed [33:0] acc;
		logic [4:0]         k;
		logic [35:0]        rr;
		logic [30:0]        term;
		logic signed [31:0] sum;
		logic [29:0]        prd;
		logic [29:0]        qe;
		logic [30:0]        e30;
		logic [30:0]        y;
		logic [16:0]        prob;
	} item_t;

endpackage

### rtl/lncdf_log_cell.sv
module lncdf_log_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  lncdf_pkg::item_t    d,
	output lncdf_pkg::item_t    q
);

	logic [61:0]      sq_full;
	logic [31:0]      sq;
	lncdf_pkg::item_t nxt;
	lncdf_pkg::item_t out_s1;

	// One fraction bit of log2 per cell: square the mantissa and renormalise.
	always_comb begin
		sq_full  = 62'(d.mant) * 62'(d.mant);
		sq       = sq_full[61:30];
		nxt      = d;
		nxt.frac = {d.frac[14:0], sq[31]};
		nxt.mant = sq[31] ? sq[31:1] : sq[30:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_s1 <= '0;
		end else if (en) begin
			out_s1 <= nxt;
		end
	end

	assign q = out_s1;

endmodule

### rtl/lncdf_div_cell.sv
module lncdf_div_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  lncdf_pkg::item_t    d,
	output lncdf_pkg::item_t    q
);

	logic [23:0]      rem2;
	logic [23:0]      diff;
	logic             ge;
	lncdf_pkg::item_t nxt;
	lncdf_pkg::item_t out_s1;

	// One restoring long-division step: bring down a numerator bit.
	always_comb begin
		rem2      = {d.rem, d.nbits[20]};
		diff      = rem2 - {1'b0, d.dvs};
		ge        = rem2 >= {1'b0, d.dvs};
		nxt       = d;
		nxt.rem   = ge ? diff[22:0] : rem2[22:0];
		nxt.nbits = {d.nbits[19:0], 1'b0};
		nxt.quo   = {d.quo[19:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_s1 <= '0;
		end else if (en) begin
			out_s1 <= nxt;
		end
	end

	assign q = out_s1;

endmodule

### rtl/lncdf_horner_cell.sv
module lncdf_horner_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic signed [33:0]  coef,
	input  lncdf_pkg::item_t    d,
	output lncdf_pkg::item_t    q
);

	logic signed [51:0] prod;
	logic signed [51:0] rnd;
	lncdf_pkg::item_t   nxt;
	lncdf_pkg::item_t   out_s1;

	always_comb begin
		prod    = d.acc * $signed({1'b0, d.quo[16:0]});
		rnd     = (prod + 52'sd32768) >>> lncdf_pkg::FRAC_BITS;
		nxt     = d;
		nxt.acc = 34'(rnd) + coef;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_s1 <= '0;
		end else if (en) begin
			out_s1 <= nxt;
		end
	end

	assign q = out_s1;

endmodule

### rtl/lncdf_exp_cell.sv
module lncdf_exp_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [4:0]          n,
	input  logic [31:0]         recip,
	input  lncdf_pkg::item_t    d,
	output lncdf_pkg::item_t    q
);

	logic [60:0]        mul_a;
	logic [61:0]        mul_b;
	logic [34:0]        qn;
	logic [34:0]        rem;
	logic [30:0]        term_n;
	logic signed [31:0] term_s;
	lncdf_pkg::item_t   a_nxt;
	lncdf_pkg::item_t   b_nxt;
	lncdf_pkg::item_t   c_nxt;
	lncdf_pkg::item_t   mul_s1;
	lncdf_pkg::item_t   quo_s2;
	lncdf_pkg::item_t   out_s3;

	// One Taylor term of exp(-r): term = floor(floor(term * r / 2^30) / n).
	always_comb begin
		mul_a     = 61'(d.term) * 61'(d.rr[29:0]);
		a_nxt     = d;
		a_nxt.prd = mul_a[59:30];
	end

	// Reciprocal estimate is exact or one below the true quotient.
	always_comb begin
		mul_b    = 62'(mul_s1.prd) * 62'(recip);
		b_nxt    = mul_s1;
		b_nxt.qe = mul_b[61:32];
	end

	always_comb begin
		qn     = 35'(quo_s2.qe) * 35'(n);
		rem    = 35'(quo_s2.prd) - qn;
		term_n = 31'(quo_s2.qe) + 31'(rem >= 35'(n));
		term_s = $signed({1'b0, term_n});
		c_nxt  = quo_s2;
		c_nxt.term = term_n;
		c_nxt.sum  = n[0] ? (quo_s2.sum - term_s) : (quo_s2.sum + term_s);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_s1 <= '0;
			quo_s2 <= '0;
			out_s3 <= '0;
		end else if (en) begin
			mul_s1 <= a_nxt;
			quo_s2 <= b_nxt;
			out_s3 <= c_nxt;
		end
	end

	assign q = out_s3;

endmodule

### rtl/lognormal_cdf_eval_core.sv
// Lognormal CDF evaluator. Each item carries an unsigned Q16.16 sample and
// returns P(X <= x) in Q1.16 for the lognormal law set by log_mean (signed
// Q8.16) and log_std_dev (Q7.16, zero is taken as one step). erf is evaluated
// with the five-term Abramowitz-Stegun 7.1.26 form. A zero sample gives
// probability 0 with bad_sample set. The block accepts one item per cycle
// while in_ready is high. Each item passes through a chain of cells:
// 16 log2 squaring cells, 21 and 17 long-division cells, 5 Horner cells
// and 16 three-stage Taylor cells for exp, plus the stages between.
// A two-entry output buffer lets input keep flowing while a result waits;
// in_ready drops only when both entries are full. Register writes are taken
// at any time but must only be made while no item is in flight.
module lognormal_cdf_eval_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] sample,
	input  logic        last_sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [16:0] probability,
	output logic        bad_sample,
	output logic        last_result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	typedef struct packed {
		logic        vld;
		logic        last;
		logic        bad;
		logic [16:0] prob;
	} res_t;

	logic signed [23:0] log_mean_q;
	logic [22:0]        log_std_dev_q;
	logic [22:0]        sigma;
	logic               pipe_en;

	lncdf_pkg::item_t in_nxt, ln_nxt, dif_nxt, za_nxt, t0_nxt;
	lncdf_pkg::item_t rng_nxt, red_nxt, e1_nxt, e2_nxt, e3_nxt;
	lncdf_pkg::item_t in_s1, ln_s2, dif_s3, za_s4, t0_s5;
	lncdf_pkg::item_t rng_s6, red_s7, e1_s8, e2_s9, e3_s10;
	lncdf_pkg::item_t lg   [17];
	lncdf_pkg::item_t dv1  [22];
	lncdf_pkg::item_t dv2  [18];
	lncdf_pkg::item_t hn   [6];
	lncdf_pkg::item_t tx   [17];

	res_t out_q;
	res_t skid_q;
	res_t pout;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_mean_q    <= '0;
			log_std_dev_q <= 23'd65536;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lncdf_pkg::REG_LOG_MEAN:    log_mean_q    <= cfg_data;
				lncdf_pkg::REG_LOG_STD_DEV: log_std_dev_q <= cfg_data[22:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign sigma     = (log_std_dev_q == '0) ? 23'd1 : log_std_dev_q;

	// Input stage: msb position and Q30 mantissa.
	always_comb begin
		logic [4:0]  m;
		logic [31:0] shl;
		m   = '0;
		shl = '0;
		for (int i = 0; i < 32; i++) begin
			if (sample[i]) begin
				m = 5'(i);
			end
		end
		shl         = sample << (5'd30 - m);
		in_nxt      = '0;
		in_nxt.vld  = in_valid;
		in_nxt.last = last_sample;
		in_nxt.bad  = (sample == '0);
		in_nxt.msb  = m;
		in_nxt.mant = (m == 5'd31) ? sample[31:1] : shl[30:0];
	end

	assign lg[0] = in_s1;

	for (genvar g = 0; g < 16; g++) begin : g_log
		lncdf_log_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(pipe_en), .d(lg[g]), .q(lg[g+1])
		);
	end

	// ln x = log2 x * ln2, rounded.
	always_comb begin
		logic signed [21:0] l2;
		logic signed [52:0] prod;
		logic signed [52:0] rnd;
		l2   = {(6'({1'b0, lg[16].msb}) - 6'd16), lg[16].frac};
		prod = l2 * $signed({1'b0, lncdf_pkg::C_LN2});
		rnd  = (prod + 53'sd536870912) >>> 30;
		ln_nxt     = lg[16];
		ln_nxt.lnv = 22'(rnd);
	end

	// Difference to the mean, sign, and set-up of the z division.
	always_comb begin
		logic signed [24:0] dv;
		logic [24:0]        ad;
		dv = 25'(ln_s2.lnv) - 25'(log_mean_q);
		ad = dv[24] ? (25'd0 - 25'(dv)) : 25'(dv);
		dif_nxt       = ln_s2;
		dif_nxt.neg   = dv[24];
		dif_nxt.rem   = 23'(ad[23:5]);
		dif_nxt.sat   = ad[23:5] >= 19'(sigma);
		if (sigma[22:19] != '0) begin
			dif_nxt.sat = 1'b0;
		end
		dif_nxt.nbits = {ad[4:0], 16'd0};
		dif_nxt.quo   = '0;
		dif_nxt.dvs   = sigma;
	end

	assign dv1[0] = dif_s3;

	for (genvar g = 0; g < 21; g++) begin : g_div1
		lncdf_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(pipe_en), .d(dv1[g]), .q(dv1[g+1])
		);
	end

	// |z| saturates at 16.0, then s = |z| / sqrt(2).
	always_comb begin
		logic [20:0] za;
		logic [50:0] prod;
		if (dv1[21].sat || dv1[21].quo > 21'd1048576) begin
			za = 21'd1048576;
		end else begin
			za = dv1[21].quo;
		end
		prod      = 51'(za) * 51'(lncdf_pkg::C_INV_SQRT2);
		prod      = prod + 51'd536870912;
		za_nxt    = dv1[21];
		za_nxt.sv = prod[49:30];
	end

	// t0 = 1 + p s, u = s^2, and set-up of the division 1 / t0.
	always_comb begin
		logic [48:0] pp;
		logic [39:0] ss;
		logic [18:0] t0;
		pp = 49'(za_s4.sv) * 49'(lncdf_pkg::C_P) + 49'd536870912;
		ss = 40'(za_s4.sv) * 40'(za_s4.sv) + 40'd32768;
		t0 = 19'd65536 + 19'(pp[48:30]);
		t0_nxt       = za_s4;
		t0_nxt.u     = ss[39:16];
		t0_nxt.rem   = 23'(16'h8000) + 23'(t0[18]);
		t0_nxt.nbits = {t0[17:1], 4'd0};
		t0_nxt.quo   = '0;
		t0_nxt.dvs   = 23'(t0);
		t0_nxt.acc   = lncdf_pkg::C_A5;
	end

	assign dv2[0] = t0_s5;

	for (genvar g = 0; g < 17; g++) begin : g_div2
		lncdf_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(pipe_en), .d(dv2[g]), .q(dv2[g+1])
		);
	end

	assign hn[0] = dv2[17];

	for (genvar g = 0; g < 5; g++) begin : g_horner
		lncdf_horner_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(pipe_en),
			.coef(lncdf_pkg::HORNER_COEF[g]), .d(hn[g]), .q(hn[g+1])
		);
	end

	// Range reduction u = k ln2 + r, upper two quotient bits.
	always_comb begin
		logic [37:0] u30;
		logic [35:0] r;
		logic [35:0] ln2w;
		u30  = {hn[5].u, 14'd0};
		ln2w = 36'(lncdf_pkg::C_LN2);
		r    = u30[35:0];
		rng_nxt      = hn[5];
		rng_nxt.k    = '0;
		rng_nxt.zero = u30 >= 38'd23816355776;
		if (hn[5].acc < 0) begin
			rng_nxt.acc = '0;
		end
		if (r >= (ln2w << 4)) begin
			r = r - (ln2w << 4);
			rng_nxt.k[4] = 1'b1;
		end
		if (r >= (ln2w << 3)) begin
			r = r - (ln2w << 3);
			rng_nxt.k[3] = 1'b1;
		end
		rng_nxt.rr = r;
	end

	// Lower three quotient bits, then start the series at one.
	always_comb begin
		logic [35:0] r;
		logic [35:0] ln2w;
		ln2w = 36'(lncdf_pkg::C_LN2);
		r    = rng_s6.rr;
		red_nxt = rng_s6;
		for (int j = 2; j >= 0; j--) begin
			if (r >= (ln2w << j)) begin
				r = r - (ln2w << j);
				red_nxt.k[j] = 1'b1;
			end
		end
		red_nxt.rr   = r;
		red_nxt.term = lncdf_pkg::Q30_ONE;
		red_nxt.sum  = 32'(lncdf_pkg::Q30_ONE);
	end

	assign tx[0] = red_s7;

	for (genvar g = 0; g < lncdf_pkg::N_TAYLOR; g++) begin : g_taylor
		lncdf_exp_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(pipe_en),
			.n(5'(g + 1)), .recip(lncdf_pkg::RECIP[g]), .d(tx[g]), .q(tx[g+1])
		);
	end

	// e^(-u) = exp(-r) >> k.
	always_comb begin
		e1_nxt = tx[16];
		if (tx[16].zero || tx[16].sum[31]) begin
			e1_nxt.e30 = '0;
		end else begin
			e1_nxt.e30 = tx[16].sum[30:0] >> tx[16].k;
		end
	end

	// erf = 1 - poly * e^(-s^2), clamped to [0, 1].
	always_comb begin
		logic [61:0]        prod;
		logic [62:0]        rp;
		logic signed [33:0] yv;
		prod = 62'(e1_s8.acc[30:0]) * 62'(e1_s8.e30);
		rp   = 63'(prod) + 63'd536870912;
		yv   = $signed(34'(lncdf_pkg::Q30_ONE)) - $signed({1'b0, rp[62:30]});
		e2_nxt = e1_s8;
		if (yv < 0) begin
			e2_nxt.y = '0;
		end else if (yv > $signed(34'(lncdf_pkg::Q30_ONE))) begin
			e2_nxt.y = lncdf_pkg::Q30_ONE;
		end else begin
			e2_nxt.y = yv[30:0];
		end
	end

	// probability = (1 +/- erf) / 2, rounded to Q16 and clamped.
	always_comb begin
		logic [31:0] p30;
		logic [31:0] half;
		logic [31:0] pr;
		p30  = e2_s9.neg ? (32'(lncdf_pkg::Q30_ONE) - 32'(e2_s9.y))
				: (32'(lncdf_pkg::Q30_ONE) + 32'(e2_s9.y));
		half = p30 >> 1;
		pr   = (half + 32'd8192) >> 14;
		e3_nxt = e2_s9;
		if (e2_s9.bad) begin
			e3_nxt.prob = '0;
		end else if (pr > 32'd65536) begin
			e3_nxt.prob = 17'd65536;
		end else begin
			e3_nxt.prob = pr[16:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_s1  <= '0;
			ln_s2  <= '0;
			dif_s3 <= '0;
			za_s4  <= '0;
			t0_s5  <= '0;
			rng_s6 <= '0;
			red_s7 <= '0;
			e1_s8  <= '0;
			e2_s9  <= '0;
			e3_s10 <= '0;
		end else if (pipe_en) begin
			in_s1  <= in_nxt;
			ln_s2  <= ln_nxt;
			dif_s3 <= dif_nxt;
			za_s4  <= za_nxt;
			t0_s5  <= t0_nxt;
			rng_s6 <= rng_nxt;
			red_s7 <= red_nxt;
			e1_s8  <= e1_nxt;
			e2_s9  <= e2_nxt;
			e3_s10 <= e3_nxt;
		end
	end

	assign pout = '{vld: e3_s10.vld, last: e3_s10.last, bad: e3_s10.bad,
			prob: e3_s10.prob};

	// The pipeline moves while the skid entry is free; an item leaving the
	// pipeline goes to the output register, or to the skid entry if busy.
	assign pipe_en  = !skid_q.vld;
	assign in_ready = pipe_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q  <= '0;
			skid_q <= '0;
		end else if (!out_q.vld || out_ready) begin
			if (skid_q.vld) begin
				out_q      <= skid_q;
				skid_q.vld <= 1'b0;
			end else begin
				out_q <= pout;
			end
		end else if (pout.vld && !skid_q.vld) begin
			skid_q <= pout;
		end
	end

	assign out_valid   = out_q.vld;
	assign probability = out_q.prob;
	assign bad_sample  = out_q.bad;
	assign last_result = out_q.last;

endmodule

### rtl/lncdf_checker.sv
`include "lognormal_cdf_eval_core_macros.svh"

module lncdf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [16:0] probability,
	input logic        bad_sample,
	input logic        last_result
);

	// A zero sample always reports probability zero.
	`LNCDF_ASSERT_NOW(a_bad_zero, clk, arst_n, out_valid && bad_sample, probability == 17'd0)

	// Probability never exceeds one.
	`LNCDF_ASSERT_NOW(a_prob_range, clk, arst_n, out_valid, probability <= 17'd65536)

	// Input is only held off while a result is waiting at the output.
	`LNCDF_ASSERT_NOW(a_stall_cause, clk, arst_n, !in_ready, out_valid)

	`LNCDF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(probability) && $stable(bad_sample) && $stable(last_result))

endmodule

bind lognormal_cdf_eval_core lncdf_checker u_lncdf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.probability(probability),
	.bad_sample(bad_sample),
	.last_result(last_result)
);
